FILE: sv/jsu_pkg.sv
`timescale 1ns / 1ps
package jsu_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U         = 8'h75;

  localparam logic [15:0] CP_TWO_BYTE   = 16'h0080;
  localparam logic [15:0] CP_THREE_BYTE = 16'h0800;
  localparam logic [7:0]  UTF8_LEAD2    = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3    = 8'hE0;
  localparam logic [7:0]  UTF8_CONT     = 8'h80;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_STRING = 2'd1,
    MODE_ESCAPE = 2'd2,
    MODE_HEX    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_END  = 2'd1,
    CMD_CP   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] data;
  } cmd_t;

  function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
    logic [3:0] res;
    res = 4'd0;
    if (ch inside {[8'h30:8'h39]}) res = 4'(ch - 8'h30);
    else if (ch inside {[8'h61:8'h66]}) res = 4'(ch - 8'h61 + 8'd10);
    else if (ch inside {[8'h41:8'h46]}) res = 4'(ch - 8'h41 + 8'd10);
    return res;
  endfunction

  function automatic logic [7:0] escape_map(input logic [7:0] ch);
    logic [7:0] res;
    case (ch)
      8'h6E:   res = 8'h0A;
      8'h74:   res = 8'h09;
      8'h72:   res = 8'h0D;
      8'h62:   res = 8'h08;
      8'h66:   res = 8'h0C;
      default: res = ch;
    endcase
    return res;
  endfunction

endpackage

FILE: sv/json_string_unescape.sv
`timescale 1ns / 1ps
// JSON string unescaper. Feed the bytes of a quoted string on in_byte, one
// item per cycle, with in_start_flag set on the opening quote. An item is
// taken when push is high and full is low. Decoded bytes come out on the
// result side as a queue: the oldest result sits on the out_ ports while
// empty is low and is taken when pop is high. out_last_of_run marks the
// final result caused by one input byte; out_string_end marks the end of
// a string (closing quote or NUL).
// Throughput: one input byte per cycle while full is low, one result per
// cycle while pop is high; a \u escape yields up to three bytes, one per
// cycle from the back end. A command is written into the queue at the edge
// that takes its input byte and moves into the output register when that
// register is empty or is being popped.
// When pop stalls, the output register holds, the command queue fills, and
// full rises after QueueDepth pending commands; input then waits.
// Reset (rst_n low, synchronous) empties both queues and returns the
// decoder to the outside-of-string state.
module json_string_unescape
  import jsu_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_start_flag,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_string_end,
  output logic       out_last_of_run
);

  logic take;
  logic q_push, q_full, q_pop, q_valid;
  cmd_t q_wdata, q_rdata;

  assign full = q_full;
  assign take = push && !q_full;

  jsu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .in_byte      (in_byte),
    .in_start_flag(in_start_flag),
    .cmd_push     (q_push),
    .cmd          (q_wdata)
  );

  jsu_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_valid(q_valid),
    .rd_data (q_rdata)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (q_valid),
    .cmd            (q_rdata),
    .cmd_pop        (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_string_end (out_string_end),
    .out_last_of_run(out_last_of_run)
  );

  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_string_end |-> !out_byte_valid && out_last_of_run)
    else $error("end result carries a byte or is not last");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command popped from empty queue");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("queues not cleared by reset");

endmodule

FILE: sv/jsu_front.sv
`timescale 1ns / 1ps
module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] in_byte,
  input  logic       in_start_flag,
  output logic       cmd_push,
  output cmd_t       cmd
);

  mode_t       mode_r, mode_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] acc_shift;

  assign acc_shift = {acc_r[11:0], hex_nibble(in_byte)};

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    if (take) begin
      if (in_start_flag) begin
        mode_nxt = MODE_STRING;
        cnt_nxt  = 2'd0;
        acc_nxt  = 16'd0;
      end else begin
        case (mode_r)
          MODE_STRING: begin
            if (in_byte == CH_NUL || in_byte == CH_QUOTE) mode_nxt = MODE_IDLE;
            else if (in_byte == CH_BACKSLASH) mode_nxt = MODE_ESCAPE;
          end
          MODE_ESCAPE: begin
            if (in_byte == CH_NUL) begin
              mode_nxt = MODE_IDLE;
            end else if (in_byte == CH_U) begin
              mode_nxt = MODE_HEX;
              cnt_nxt  = 2'd0;
              acc_nxt  = 16'd0;
            end else begin
              mode_nxt = MODE_STRING;
            end
          end
          MODE_HEX: begin
            if (in_byte == CH_NUL) begin
              mode_nxt = MODE_IDLE;
              cnt_nxt  = 2'd0;
              acc_nxt  = 16'd0;
            end else if (cnt_r == 2'd3) begin
              mode_nxt = MODE_STRING;
              cnt_nxt  = 2'd0;
              acc_nxt  = 16'd0;
            end else begin
              cnt_nxt = cnt_r + 2'd1;
              acc_nxt = acc_shift;
            end
          end
          default: mode_nxt = mode_r;
        endcase
      end
    end
  end

  always_comb begin
    cmd_push  = 1'b0;
    cmd.kind  = CMD_BYTE;
    cmd.data  = {8'd0, in_byte};
    if (take && !in_start_flag) begin
      case (mode_r)
        MODE_STRING: begin
          if (in_byte == CH_NUL || in_byte == CH_QUOTE) begin
            cmd_push = 1'b1;
            cmd.kind = CMD_END;
          end else if (in_byte != CH_BACKSLASH) begin
            cmd_push = 1'b1;
          end
        end
        MODE_ESCAPE: begin
          if (in_byte == CH_NUL) begin
            cmd_push = 1'b1;
            cmd.kind = CMD_END;
          end else if (in_byte != CH_U) begin
            cmd_push = 1'b1;
            cmd.data = {8'd0, escape_map(in_byte)};
          end
        end
        MODE_HEX: begin
          if (in_byte == CH_NUL) begin
            cmd_push = 1'b1;
            cmd.kind = CMD_END;
          end else if (cnt_r == 2'd3) begin
            cmd_push = 1'b1;
            cmd.kind = CMD_CP;
            cmd.data = acc_shift;
          end
        end
        default: cmd_push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cnt_r  <= 2'd0;
      acc_r  <= 16'd0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

FILE: sv/jsu_queue.sv
`timescale 1ns / 1ps
module jsu_queue
  import jsu_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output cmd_t rd_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_wr, do_rd;

  assign full     = (count_r == CntW'(Depth));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_wr && !do_rd) count_nxt = count_r + 1'b1;
    else if (do_rd && !do_wr) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: sv/jsu_back.sv
`timescale 1ns / 1ps
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_string_end,
  output logic       out_last_of_run
);

  logic [1:0]  step_r, step_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        bval_r, bval_nxt;
  logic        end_r, end_nxt;
  logic        last_r, last_nxt;
  logic        load;
  logic [1:0]  n_res;
  logic [7:0]  sel_byte;
  logic        is_last;
  logic [15:0] cp;

  assign cp = cmd.data;

  always_comb begin
    n_res    = 2'd1;
    sel_byte = cp[7:0];
    case (cmd.kind)
      CMD_BYTE: sel_byte = cp[7:0];
      CMD_END:  sel_byte = 8'd0;
      CMD_CP: begin
        if (cp < CP_TWO_BYTE) begin
          sel_byte = cp[7:0];
        end else if (cp < CP_THREE_BYTE) begin
          n_res    = 2'd2;
          sel_byte = (step_r == 2'd0) ? (UTF8_LEAD2 | {3'd0, cp[10:6]})
                                      : (UTF8_CONT | {2'd0, cp[5:0]});
        end else begin
          n_res = 2'd3;
          case (step_r)
            2'd0:    sel_byte = UTF8_LEAD3 | {4'd0, cp[15:12]};
            2'd1:    sel_byte = UTF8_CONT | {2'd0, cp[11:6]};
            default: sel_byte = UTF8_CONT | {2'd0, cp[5:0]};
          endcase
        end
      end
      default: sel_byte = 8'd0;
    endcase
  end

  assign is_last = (step_r == n_res - 2'd1);
  assign load    = cmd_valid && (!valid_r || pop);
  assign cmd_pop = load && is_last;

  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    bval_nxt  = bval_r;
    end_nxt   = end_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      byte_nxt  = sel_byte;
      bval_nxt  = (cmd.kind != CMD_END);
      end_nxt   = (cmd.kind == CMD_END);
      last_nxt  = is_last;
      step_nxt  = is_last ? 2'd0 : step_r + 2'd1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    bval_r <= bval_nxt;
    end_r  <= end_nxt;
    last_r <= last_nxt;
  end

  assign empty           = !valid_r;
  assign out_byte        = byte_r;
  assign out_byte_valid  = bval_r;
  assign out_string_end  = end_r;
  assign out_last_of_run = last_r;

endmodule
